// ===== rtl/drpp_pkg.sv =====
// Package: shared types and constants for the readout packet parser.
`timescale 1ns / 1ps
`default_nettype none
package drpp_pkg;

  localparam logic [31:0] EofMark  = 32'hfafafafa;
  localparam logic [31:0] NodataId = 32'h56413200;
  localparam logic [31:0] IdMask   = 32'hffffff00;
  localparam logic [31:0] DataId   = 32'h564d3200;
  localparam logic [15:0] LenMask  = 16'hfff8;
  localparam logic [13:0] PosMax   = 14'd16383;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = 2;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_DONE    = 3'd1,
    ST_EOF     = 3'd2,
    ST_NODATA  = 3'd3,
    ST_UNDER   = 3'd4,
    ST_UNKNOWN = 3'd5,
    ST_NOROOM  = 3'd6,
    ST_BADLEN  = 3'd7
  } status_e;

  // One front-to-back command: optional hit words plus optional summary.
  typedef struct packed {
    logic        has_hit;
    logic [31:0] w1;
    logic [31:0] w2;
    logic        has_sum;
    status_e     status;
    logic [12:0] hit_count;
    logic [16:0] error_count;
    logic [31:0] frame_time;
    logic [31:0] time_wraps;
  } cmd_t;

  // Result item fields in output order.
  typedef struct packed {
    logic        last_of_run;
    status_e     status;
    logic [7:0]  tdc;
    logic [9:0]  adc;
    logic [11:0] bcid;
    logic [5:0]  channel;
    logic        above_thresh;
    logic [12:0] hit_count;
    logic [16:0] error_count;
    logic [31:0] frame_time;
    logic [31:0] time_wraps;
    logic [31:0] bcid_tdc_errors;
  } res_t;

  function automatic logic [31:0] bit_rev(input logic [31:0] x);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = x[31-i];
    return r;
  endfunction

  function automatic logic [11:0] gray2bin(input logic [11:0] g);
    logic [11:0] b;
    b[11] = g[11];
    for (int i = 10; i >= 0; i--) b[i] = b[i+1] ^ g[i];
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/drpp_front.sv =====
// Front end: header checks, hit pairing and packet bookkeeping.
`timescale 1ns / 1ps
`default_nettype none
module drpp_front import drpp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] word_i,
  input  wire logic [15:0] bytes_i,
  input  wire logic        last_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i,
  output cmd_t             cmd_o
);

  logic [12:0] max_hits_q;
  logic [13:0] pos_q, pos_d;
  logic [31:0] hfc_q, hfc_d, first_q, first_d, ptime_q, ptime_d, pfc_q, pfc_d;
  logic [31:0] wraps_q, wraps_d, htime_q, htime_d;
  logic [12:0] hits_q, hits_d;
  logic [16:0] errs_q, errs_d;
  status_e     st_q, st_d;
  logic        acc;
  logic [15:0] dlen;
  logic [13:0] off;
  logic [12:0] pairs;
  logic        capped;

  assign in_ready_o  = cmd_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign dlen        = bytes_i - 16'd12;
  assign off         = pos_q - 14'd3;
  assign pairs       = dlen[15:3];
  assign capped      = (max_hits_q != '0) && (hits_q >= max_hits_q);

  // Classify the word by its place in the packet.
  always_comb begin
    pos_d = pos_q; hfc_d = hfc_q; first_d = first_q; ptime_d = ptime_q;
    pfc_d = pfc_q; wraps_d = wraps_q; htime_d = htime_q; hits_d = hits_q;
    errs_d = errs_q; st_d = st_q;
    cmd_o = '0;
    cmd_valid_o = 1'b0;
    if (pos_q == 14'd0) begin
      hits_d = '0; errs_d = '0; st_d = ST_HIT; htime_d = '0; hfc_d = word_i;
      if (bytes_i < 16'd4) begin
        st_d = ST_UNDER; errs_d = 17'(bytes_i);
      end else if (word_i == EofMark) begin
        st_d = ST_EOF;
      end else if (bytes_i < 16'd12) begin
        st_d = ST_UNDER; errs_d = 17'(bytes_i);
      end
    end else if (pos_q == 14'd1) begin
      if (st_q == ST_HIT) begin
        if (word_i == NodataId) begin
          st_d = ST_NODATA;
        end else if ((word_i & IdMask) != DataId) begin
          st_d = ST_UNKNOWN; errs_d = errs_q + 17'(bytes_i);
        end else begin
          if (hfc_q < pfc_q && !(pfc_q[31] && !hfc_q[31])) errs_d = errs_q + 17'd1;
          pfc_d = hfc_q;
          if (bytes_i < 16'd20) begin
            st_d = ST_NOROOM; errs_d = errs_d + 17'(bytes_i);
          end else if ((dlen & LenMask) != dlen) begin
            st_d = ST_BADLEN; errs_d = errs_d + 17'(bytes_i);
          end
        end
      end
    end else if (pos_q == 14'd2) begin
      if (st_q != ST_EOF && st_q != ST_UNDER) begin
        htime_d = word_i; ptime_d = word_i;
        if (word_i < ptime_q) wraps_d = wraps_q + 32'd1;
      end
    end else if (st_q == ST_HIT) begin
      // A length below the header size leaves the pair limit unbounded.
      if (((bytes_i < 16'd12) || ({1'b0, off[13:1]} < {1'b0, pairs})) && !capped) begin
        if (!off[0]) begin
          first_d = word_i;
        end else begin
          cmd_o.has_hit = 1'b1;
          cmd_o.w1 = first_q;
          cmd_o.w2 = word_i;
          hits_d = hits_q + 13'd1;
        end
      end
    end
    if (last_i) begin
      if (st_d == ST_HIT && pos_q < 14'd2) begin
        st_d = ST_UNDER; errs_d = errs_d + 17'(bytes_i);
      end
      cmd_o.has_sum = 1'b1;
      cmd_o.status = (st_d == ST_HIT) ? ST_DONE : st_d;
      cmd_o.hit_count = hits_d;
      cmd_o.error_count = errs_d;
      cmd_o.frame_time = htime_d;
      cmd_o.time_wraps = wraps_d;
      pos_d = '0;
    end else if (pos_q < PosMax) begin
      pos_d = pos_q + 14'd1;
    end
    cmd_valid_o = in_valid_i && (cmd_o.has_hit || cmd_o.has_sum);
  end

  // Update packet state on each accepted item; take max_hits on a config write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_hits_q <= 13'd8191; pos_q <= '0; hfc_q <= '0; ptime_q <= '0;
      pfc_q <= '0; wraps_q <= '0; htime_q <= '0; hits_q <= '0; errs_q <= '0;
      st_q <= ST_HIT;
    end else begin
      if (cfg_we_i) max_hits_q <= cfg_wdata_i;
      if (acc) begin
        pos_q <= pos_d; hfc_q <= hfc_d; ptime_q <= ptime_d; pfc_q <= pfc_d;
        wraps_q <= wraps_d; htime_q <= htime_d; hits_q <= hits_d;
        errs_q <= errs_d; st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) first_q <= first_d;
  end

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !last_i && pos_q == PosMax |=> pos_q == PosMax) else $error("pos sat");
  a_last_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_i |=> pos_q == 14'd0) else $error("pos clear");
  a_hit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.has_hit |-> pos_q > 14'd3) else $error("hit early");

endmodule
`default_nettype wire

// ===== rtl/drpp_queue.sv =====
// Short command queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module drpp_queue import drpp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  cmd_t      in_cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      out_cmd_o
);

  cmd_t          mem_q [QDepth];
  logic [QAw-1:0] wp_q, rp_q;
  logic [QAw:0]   cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != QAw'(0) + (QAw+1)'(QDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_cmd_o   = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAw+1)'(QDepth)) else $error("queue overflow");

endmodule
`default_nettype wire

// ===== rtl/drpp_back.sv =====
// Back end: decodes hit words and emits hit and summary items.
`timescale 1ns / 1ps
`default_nettype none
module drpp_back import drpp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  logic        hit_done_q;
  logic [31:0] bad_q, bad_d, d1, d2;
  logic        do_hit, do_sum, emit, out_free;
  res_t        r_d, res_q;
  logic        vld_q;
  logic [7:0]  tdc;
  logic [11:0] bcid;

  assign d1 = bit_rev(cmd_i.w1);
  assign d2 = bit_rev(cmd_i.w2);
  assign tdc = {d1[9:8], d1[23:18]};
  assign bcid = gray2bin({d1[5:0], d1[15:10]});
  assign out_free = !vld_q || res_ready_i;
  assign do_hit = cmd_valid_i && cmd_i.has_hit && !hit_done_q;
  assign do_sum = cmd_valid_i && !do_hit;
  assign emit = out_free && cmd_valid_i;
  assign cmd_ready_o = out_free && (do_sum || !cmd_i.has_sum);

  // Build the next result item.
  always_comb begin
    r_d = '0;
    bad_d = bad_q;
    if (do_hit) begin
      if (bcid == '0 && tdc == '0 && d2[1]) bad_d = bad_q + 32'd1;
      r_d.status = ST_HIT;
      r_d.tdc = tdc;
      r_d.adc = {d1[17:16], d1[31:24]};
      r_d.bcid = bcid;
      r_d.channel = d2[7:2];
      r_d.above_thresh = d2[1];
      r_d.last_of_run = !cmd_i.has_sum;
    end else begin
      r_d.status = cmd_i.status;
      r_d.hit_count = cmd_i.hit_count;
      r_d.error_count = cmd_i.error_count;
      r_d.frame_time = cmd_i.frame_time;
      r_d.time_wraps = cmd_i.time_wraps;
      r_d.last_of_run = 1'b1;
    end
    r_d.bcid_tdc_errors = bad_d;
  end

  // Hold the output register until taken; on each emit, update the error count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0; bad_q <= '0; hit_done_q <= 1'b0;
    end else begin
      if (out_free) vld_q <= cmd_valid_i;
      if (emit) begin
        bad_q <= bad_d;
        hit_done_q <= do_hit && cmd_i.has_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= r_d;
  end

  assign res_valid_o = vld_q;
  assign res_o = res_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> $stable(res_q)) else $error("out hold");
  a_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_done_q |-> cmd_valid_i) else $error("split lost");
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_q != $past(bad_q) |-> $past(do_hit && emit)) else $error("bad count");

endmodule
`default_nettype wire

// ===== rtl/detector_readout_packet_parser_unit.sv =====
// Top level: readout packet parser, front end, command queue and back end.
`timescale 1ns / 1ps
`default_nettype none
// Takes one packet word per clock when the queue has room. The front end
// checks the header and pairs hit words; a four-entry command queue feeds the
// back end, which decodes hits and writes one result item per cycle into a
// registered output while it is free. A word that ends a packet and completes
// a hit yields two items and holds the back end until both are out; the queue
// absorbs this, so sustained rate is one word per cycle unless output stalls.
module detector_readout_packet_parser_unit import drpp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [12:0]  cfg_wdata_i,   // max_hits
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [47:0]  s_axis_tdata,  // word[31:0], packet_bytes[47:32]
  input  wire logic         s_axis_tlast,  // last_word
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // packet_status, tdc, adc, bcid, channel, above_thresh, hit_count,
  // error_count, frame_time, time_wraps, bcid_tdc_errors from bit 0 up
  output logic [167:0]      m_axis_tdata,
  output logic              m_axis_tlast   // last_of_run
);

  logic cv, cr, qv, qr;
  cmd_t cmd, qcmd;
  res_t res;

  drpp_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .word_i(s_axis_tdata[31:0]), .bytes_i(s_axis_tdata[47:32]),
    .last_i(s_axis_tlast),
    .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_o(cmd)
  );

  drpp_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(cv), .in_ready_o(cr), .in_cmd_i(cmd),
    .out_valid_o(qv), .out_ready_i(qr), .out_cmd_o(qcmd)
  );

  drpp_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(qv), .cmd_ready_o(qr), .cmd_i(qcmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tlast = res.last_of_run;
  assign m_axis_tdata = {2'b00, res.bcid_tdc_errors, res.time_wraps, res.frame_time,
                         res.error_count, res.hit_count, res.above_thresh,
                         res.channel, res.bcid, res.adc, res.tdc, res.status};

endmodule
`default_nettype wire
